// ===== rtl/spq_pkg.sv =====
`timescale 1ns / 1ps

package spq_pkg;

    localparam int DEPTH         = 16;
    localparam int PRIORITY_BITS = 8;
    localparam int HANDLE_BITS   = 16;
    localparam int CNT_W         = $clog2(DEPTH + 1);

    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [PRIORITY_BITS-1:0] pri;
        logic [HANDLE_BITS-1:0]   hnd;
    } entry_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic push;
        logic pop;
    } cell_ctrl_t;

endpackage

// ===== rtl/stable_priority_queue.sv =====
`timescale 1ns / 1ps

// Sorted priority queue of up to DEPTH task handles, highest priority at the front, equal
// priorities served in arrival order. One item is taken per clock: busy never rises, so
// start may stay high every cycle. The result for an item appears with done high on the
// cycle right after the item was taken, and it must be captured then: there is no way to
// hold it off. Entries live in a row of DEPTH cells; a push or pop moves every cell by at
// most one place per item, which sets the one-item-per-cycle rate. A push into a full
// queue is dropped and reported; a pop of an empty queue is reported and changes nothing.
module stable_priority_queue
    import spq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               opcode,
    input  logic [HANDLE_BITS-1:0]   task_handle,
    input  logic [PRIORITY_BITS-1:0] priority_req,
    output logic                     done,
    output logic [HANDLE_BITS-1:0]   popped_handle,
    output logic [1:0]               status,
    output logic [HANDLE_BITS-1:0]   front_handle,
    output logic [PRIORITY_BITS-1:0] front_priority,
    output logic [CNT_W-1:0]         entry_count,
    output logic                     queue_empty
);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             done_reg;
    logic [HANDLE_BITS-1:0]   popped_reg, popped_next;
    logic [1:0]               status_reg, status_next;
    logic [HANDLE_BITS-1:0]   front_hnd_reg;
    logic [PRIORITY_BITS-1:0] front_pri_reg;

    logic       accept, is_full, is_empty;
    cell_ctrl_t ctrl;
    entry_t     new_entry;
    entry_t     cell_entry [DEPTH];
    entry_t     cell_next  [DEPTH];
    logic       cell_keep  [DEPTH];

    assign busy      = 1'b0;
    assign accept    = start && !busy;
    assign is_full   = (count_reg == CNT_W'(DEPTH));
    assign is_empty  = (count_reg == '0);
    assign new_entry = '{pri: priority_req, hnd: task_handle};

    always_comb
    begin
        ctrl        = '0;
        count_next  = count_reg;
        status_next = ST_OK;
        popped_next = '0;
        if (accept)
        begin
            case (opcode)
                OP_PUSH:
                begin
                    if (is_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        ctrl.push  = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                OP_POP:
                begin
                    if (is_empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        ctrl.pop    = 1'b1;
                        count_next  = count_reg - 1'b1;
                        popped_next = cell_entry[0].hnd;
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        entry_t left_e, right_e;
        logic   left_k;

        if (i == 0)
        begin : g_head
            assign left_e = new_entry;
            assign left_k = 1'b1;
        end
        else
        begin : g_mid
            assign left_e = cell_entry[i-1];
            assign left_k = cell_keep[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_e = new_entry;
        end
        else
        begin : g_body
            assign right_e = cell_entry[i+1];
        end

        spq_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .valid       (count_reg > CNT_W'(i)),
            .new_entry   (new_entry),
            .left_entry  (left_e),
            .left_keep   (left_k),
            .right_entry (right_e),
            .entry       (cell_entry[i]),
            .entry_next  (cell_next[i]),
            .keep        (cell_keep[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        popped_reg <= popped_next;
        status_reg <= status_next;
        if (count_next == '0)
        begin
            front_hnd_reg <= '0;
            front_pri_reg <= '0;
        end
        else
        begin
            front_hnd_reg <= cell_next[0].hnd;
            front_pri_reg <= cell_next[0].pri;
        end
    end

    assign done           = done_reg;
    assign popped_handle  = popped_reg;
    assign status         = status_reg;
    assign front_handle   = front_hnd_reg;
    assign front_priority = front_pri_reg;
    assign entry_count    = count_reg;
    assign queue_empty    = (count_reg == '0);

endmodule

// ===== rtl/spq_cell.sv =====
`timescale 1ns / 1ps

module spq_cell
    import spq_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  logic       valid,
    input  entry_t     new_entry,
    input  entry_t     left_entry,
    input  logic       left_keep,
    input  entry_t     right_entry,
    output entry_t     entry,
    output entry_t     entry_next,
    output logic       keep
);

    entry_t entry_reg;

    // an entry of greater or equal priority stays ahead of the new one
    assign keep = valid && (entry_reg.pri >= new_entry.pri);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.push)
        begin
            if (!keep)
            begin
                entry_next = left_keep ? new_entry : left_entry;
            end
        end
        else if (ctrl.pop)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== rtl/spq_checker.sv =====
`timescale 1ns / 1ps

module spq_checker
    import spq_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     start,
    input logic                     busy,
    input logic [1:0]               opcode,
    input logic                     done,
    input logic [1:0]               status,
    input logic [HANDLE_BITS-1:0]   popped_handle,
    input logic [HANDLE_BITS-1:0]   front_handle,
    input logic [PRIORITY_BITS-1:0] front_priority,
    input logic [CNT_W-1:0]         entry_count,
    input logic                     queue_empty
);

    // one result for every item taken, on the next cycle
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("item taken without a result");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entry_count <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    a_empty_front: assert property (@(posedge clk) disable iff (!rst_n)
        (done && queue_empty) |-> (front_handle == '0 && front_priority == '0
                                   && entry_count == '0))
        else $error("empty queue reports a front entry");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_FULL) |-> (entry_count == CNT_W'(DEPTH)
                                         && popped_handle == '0))
        else $error("dropped push while not full");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && opcode == OP_POP && entry_count != '0)
            |=> (entry_count == $past(entry_count) - 1'b1 && status == ST_OK))
        else $error("pop did not remove one entry");

endmodule

bind stable_priority_queue spq_checker u_spq_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .opcode         (opcode),
    .done           (done),
    .status         (status),
    .popped_handle  (popped_handle),
    .front_handle   (front_handle),
    .front_priority (front_priority),
    .entry_count    (entry_count),
    .queue_empty    (queue_empty)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import spq_pkg::*;

    // opcodes the package leaves unnamed: both only report status
    localparam logic [1:0] OP_NOP   = 2'd2;
    localparam logic [1:0] OP_SPARE = 2'd3;

    localparam int MAX_REPORTS = 10;
    localparam int DRAIN_LIMIT = 1000;
    localparam int TAIL_CYCLES = 4;

    typedef enum int {EP_FILL, EP_DRAIN, EP_MIX} episode_t;

    typedef struct packed {
        logic [HANDLE_BITS-1:0]   popped;
        logic [1:0]               status;
        logic [HANDLE_BITS-1:0]   front_hnd;
        logic [PRIORITY_BITS-1:0] front_pri;
        logic [CNT_W-1:0]         count;
        logic                     empty;
    } queue_status_t;

    logic                     clk;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [1:0]               opcode = OP_NOP;
    logic [HANDLE_BITS-1:0]   task_handle = '0;
    logic [PRIORITY_BITS-1:0] priority_req = '0;
    logic                     done;
    logic [HANDLE_BITS-1:0]   popped_handle;
    logic [1:0]               status;
    logic [HANDLE_BITS-1:0]   front_handle;
    logic [PRIORITY_BITS-1:0] front_priority;
    logic [CNT_W-1:0]         entry_count;
    logic                     queue_empty;

    // sorted shadow of the queue contents, front at index 0
    logic [PRIORITY_BITS-1:0] held_pri [DEPTH];
    logic [HANDLE_BITS-1:0]   held_hnd [DEPTH];
    int                       held_count = 0;

    queue_status_t            pending_results [$];
    int                       fail_count = 0;

    // stimulus side bookkeeping
    int                       idle_pct = 0;
    int                       fill_level = 0;
    int                       items_sent = 0;
    logic [PRIORITY_BITS-1:0] tie_pri = '0;

    stable_priority_queue DUT
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .opcode         (opcode),
        .task_handle    (task_handle),
        .priority_req   (priority_req),
        .done           (done),
        .popped_handle  (popped_handle),
        .status         (status),
        .front_handle   (front_handle),
        .front_priority (front_priority),
        .entry_count    (entry_count),
        .queue_empty    (queue_empty)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #200000;
        $display("*** FAILED ***");
        $finish;
    end

    // apply one item to the shadow queue and return the status it should report
    function automatic queue_status_t queue_step(input logic [1:0] op,
                                                 input logic [HANDLE_BITS-1:0] hnd,
                                                 input logic [PRIORITY_BITS-1:0] pri);
        queue_status_t r;
        int            pos;
        int            k;
        r = '0;
        r.status = ST_OK;
        if (op == OP_PUSH)
        begin
            if (held_count >= DEPTH)
                r.status = ST_FULL;
            else
            begin
                // stable insert: goes behind every entry of equal or higher priority
                pos = 0;
                while (pos < held_count && held_pri[pos] >= pri)
                    pos++;
                for (k = held_count; k > pos; k--)
                begin
                    held_pri[k] = held_pri[k-1];
                    held_hnd[k] = held_hnd[k-1];
                end
                held_pri[pos] = pri;
                held_hnd[pos] = hnd;
                held_count++;
            end
        end
        else if (op == OP_POP)
        begin
            if (held_count == 0)
                r.status = ST_EMPTY;
            else
            begin
                r.popped = held_hnd[0];
                for (k = 1; k < held_count; k++)
                begin
                    held_pri[k-1] = held_pri[k];
                    held_hnd[k-1] = held_hnd[k];
                end
                held_count--;
            end
        end
        if (held_count > 0)
        begin
            r.front_hnd = held_hnd[0];
            r.front_pri = held_pri[0];
        end
        r.count = held_count[CNT_W-1:0];
        r.empty = (held_count == 0);
        return r;
    endfunction

    // results first (they belong to earlier items), then the item taken at this edge
    always @(posedge clk)
    begin
        queue_status_t seen;
        queue_status_t want;
        if (rst_n)
        begin
            if (done)
            begin
                seen.popped    = popped_handle;
                seen.status    = status;
                seen.front_hnd = front_handle;
                seen.front_pri = front_priority;
                seen.count     = entry_count;
                seen.empty     = queue_empty;
                if (pending_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: result with no item outstanding", $realtime);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (seen !== want)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                        begin
                            $display("%0t: mismatch  field: expected / actual", $realtime);
                            $display("  popped_handle  %h / %h", want.popped, seen.popped);
                            $display("  status         %0d / %0d", want.status, seen.status);
                            $display("  front_handle   %h / %h", want.front_hnd,
                                     seen.front_hnd);
                            $display("  front_priority %0d / %0d", want.front_pri,
                                     seen.front_pri);
                            $display("  entry_count    %0d / %0d", want.count, seen.count);
                            $display("  queue_empty    %0d / %0d", want.empty, seen.empty);
                        end
                    end
                end
            end
            if (start && !busy)
                pending_results.push_back(queue_step(opcode, task_handle, priority_req));
        end
    end

    task automatic send_item(input logic [1:0] op,
                             input logic [HANDLE_BITS-1:0] hnd,
                             input logic [PRIORITY_BITS-1:0] pri);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start        <= 1'b1;
        opcode       <= op;
        task_handle  <= hnd;
        priority_req <= pri;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (op == OP_PUSH && fill_level < DEPTH)
            fill_level++;
        else if (op == OP_POP && fill_level > 0)
            fill_level--;
        items_sent++;
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic test_empty_queue();
        send_item(OP_POP, 16'hFFFF, 8'hFF);
        send_item(OP_NOP, 16'h1234, 8'h12);
        send_item(OP_SPARE, 16'hFFFF, 8'hFF);
    endtask

    // fill to the brim with extremes and ties, then overflow and pop a couple
    task automatic test_fill_and_overflow();
        logic [PRIORITY_BITS-1:0] pris [16];
        logic [HANDLE_BITS-1:0]   hnd;
        int                       i;
        pris = '{8'd0, 8'd255, 8'd128, 8'd255, 8'd0, 8'd7, 8'd128, 8'd1,
                 8'd254, 8'd128, 8'd0, 8'd255, 8'd64, 8'd64, 8'd200, 8'd3};
        for (i = 0; i < DEPTH; i++)
        begin
            if (i == 0)
                hnd = '0;
            else if (i == 1)
                hnd = '1;
            else
                hnd = HANDLE_BITS'($urandom_range(0, 65535));
            send_item(OP_PUSH, hnd, pris[i % 16]);
        end
        send_item(OP_PUSH, 16'hBEEF, 8'd255);
        send_item(OP_SPARE, 16'h0000, 8'd0);
        send_item(OP_POP, 16'h0000, 8'd0);
        send_item(OP_POP, 16'hFFFF, 8'd0);
    endtask

    function automatic logic [PRIORITY_BITS-1:0] pick_priority();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        else if (r < 6)
            return PRIORITY_BITS'(tie_pri + $urandom_range(0, 1));
        else
            return PRIORITY_BITS'($urandom_range(0, 255));
    endfunction

    // push_pct pushes, a tenth status-only, the rest pops
    task automatic send_biased(input int push_pct);
        int         r;
        logic [1:0] op;
        r = $urandom_range(0, 99);
        if (r < push_pct)
            op = OP_PUSH;
        else if (r < push_pct + 10)
            op = $urandom_range(0, 1) ? OP_NOP : OP_SPARE;
        else
            op = OP_POP;
        send_item(op, HANDLE_BITS'($urandom_range(0, 65535)), pick_priority());
    endtask

    task automatic test_random_traffic(input int n_items);
        int       target;
        int       halfway;
        logic     paused;
        episode_t ep;
        target  = items_sent + n_items;
        halfway = items_sent + n_items / 2;
        paused  = 1'b0;
        while (items_sent < target)
        begin
            if (!paused && items_sent >= halfway)
            begin
                wait_for_results();
                paused = 1'b1;
            end
            ep = episode_t'($urandom_range(0, 2));
            tie_pri = PRIORITY_BITS'($urandom_range(0, 255));
            case (ep)
                EP_FILL:
                begin
                    while (fill_level < DEPTH)
                        send_biased(75);
                    repeat ($urandom_range(1, 3))
                        send_item(OP_PUSH, HANDLE_BITS'($urandom_range(0, 65535)),
                                  pick_priority());
                end
                EP_DRAIN:
                begin
                    while (fill_level > 0)
                        send_biased(15);
                    repeat ($urandom_range(1, 2))
                        send_item(OP_POP, HANDLE_BITS'($urandom_range(0, 65535)),
                                  pick_priority());
                end
                default:
                begin
                    repeat ($urandom_range(10, 30))
                        send_biased(45);
                end
            endcase
        end
    endtask

    initial
    begin
        int drain_cycles;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_queue();
        test_fill_and_overflow();
        wait_for_results();

        idle_pct = 0;
        test_random_traffic(400);
        wait_for_results();
        idle_pct = 53;
        test_random_traffic(400);
        wait_for_results();
        idle_pct = 6;
        test_random_traffic(400);

        start <= 1'b0;
        drain_cycles = 0;
        while (pending_results.size() != 0 && drain_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            $display("%0d results never arrived", pending_results.size());

        if (fail_count == 0 && pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/stable_priority_queue.sv
rtl/spq_checker.sv
tb/testbench.sv
